### src/ppq_pkg.sv
// Package for the priority push-out queue: constants, codes and cell types.
// No dependencies.
package ppq_pkg;
  localparam int QueueDepthDef = 16;
  localparam int SizeBitsDef = 32;
  localparam int TagBitsDef = 32;
  localparam int CntW = 32;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP = 2'd1,
    CMD_DRAIN = 2'd2,
    CMD_STAT = 2'd3
  } cmd_t;

  localparam logic [2:0] ST_ACCEPT = 3'd0;
  localparam logic [2:0] ST_OVF = 3'd1;
  localparam logic [2:0] ST_EMERG = 3'd2;
  localparam logic [2:0] ST_POPPED = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;
  localparam logic [2:0] ST_DRAINED = 3'd5;
  localparam logic [2:0] ST_STAT = 3'd6;

  localparam logic [1:0] PRI_P0 = 2'd0;
  localparam logic [1:0] PRI_P1 = 2'd1;
  localparam logic [1:0] PRI_P2 = 2'd2;
  localparam logic [1:0] PRI_P3 = 2'd3;

  localparam logic CFG_ITEM_LIMIT = 1'b0;
  localparam logic CFG_BYTE_LIMIT = 1'b1;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic shift;    // close the gap: cell i takes cell i+1 when i >= rm_pos
    logic load;     // write the newcomer into the tail cell
    logic clear;    // drain
  } cell_ctl_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction
endpackage

### src/ppq_cell.sv
// One slot of the ordered row: holds priority, size and tag, shifts toward head.
// Depends on ppq_pkg.
module ppq_cell #(
  parameter int SIZE_BITS = 32,
  parameter int TAG_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ppq_pkg::cell_ctl_t    ctl,
  input  logic                  shift_en,   // this cell is at or past the removed slot
  input  logic                  load_en,    // this cell is the tail
  input  logic                  nb_valid,
  input  logic [1:0]            nb_pri,
  input  logic [SIZE_BITS-1:0]  nb_size,
  input  logic [TAG_BITS-1:0]   nb_tag,
  input  logic [1:0]            new_pri,
  input  logic [SIZE_BITS-1:0]  new_size,
  input  logic [TAG_BITS-1:0]   new_tag,
  output logic                  valid,
  output logic [1:0]            pri,
  output logic [SIZE_BITS-1:0]  size,
  output logic [TAG_BITS-1:0]   tag
);
  import ppq_pkg::*;
  logic valid_r, valid_nxt;
  logic [1:0] pri_r, pri_nxt;
  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;

  always_comb begin
    valid_nxt = valid_r;
    pri_nxt = pri_r;
    size_nxt = size_r;
    tag_nxt = tag_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.shift && shift_en) begin
      valid_nxt = nb_valid;
      pri_nxt = nb_pri;
      size_nxt = nb_size;
      tag_nxt = nb_tag;
    end else if (ctl.load && load_en) begin
      valid_nxt = 1'b1;
      pri_nxt = new_pri;
      size_nxt = new_size;
      tag_nxt = new_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
    pri_r <= pri_nxt;
    size_r <= size_nxt;
    tag_r <= tag_nxt;
  end

  assign valid = valid_r;
  assign pri = pri_r;
  assign size = size_r;
  assign tag = tag_r;
endmodule

### src/priority_pushout_queue.sv
// Priority push-out queue: a row of shifting cells in arrival order.
// Commands enter on in_*, one result item per command leaves on out_*,
// limits are written on cfg_*; the user must write them only while the block is idle,
// and the block itself does not enforce it.
// Steps from the accepting edge to out_tvalid, for each command:
// Push: check, then finish when there is room. Each eviction adds a scan per
// candidate class (priority 3, then 2, then 1 for a priority-0 item) over the
// held cells, a removal and another check.
// Pop: a scan over the held cells, a removal, then finish.
// Drain: a scan that counts each held cell, then finish.
// Stat: finish only.
// Rate is set by the single scan pointer walking the cell row.
// One item is worked on at a time; in_tready is low while busy or while
// the result register is still full. The result waits in an output
// register until out_tready; a stall holds it and blocks the next command.
// Reset (rst_n low, synchronous) empties the row, zeroes counters and
// restores item_limit 16 and byte_limit 1048576.
module priority_pushout_queue
  import ppq_pkg::*;
#(
  parameter int QUEUE_DEPTH = ppq_pkg::QueueDepthDef,
  parameter int SIZE_BITS = ppq_pkg::SizeBitsDef,
  parameter int TAG_BITS = ppq_pkg::TagBitsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // command[1:0], item_priority[3:2], item_size, item_tag, stat_index
  input  logic [((7+SIZE_BITS+TAG_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // status[2:0], out_tag[34:3], out_priority[36:35], out_size[68:37],
  // evicted_now[73:69], held_items[78:74], held_bytes[110:79], stat_value[142:111]
  output logic [143:0] out_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_REM   = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_POPS  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0] item_limit_r;
  logic [31:0] byte_limit_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [SIZE_BITS-1:0] bytes_r, bytes_nxt;
  logic [CntW-1:0] drops_r [4];
  logic [CntW-1:0] pre_r, ovf_r, emg_r;
  logic [1:0] cmd_r, ipri_r;
  logic [SIZE_BITS-1:0] isize_r;
  logic [TAG_BITS-1:0] itag_r;
  logic [2:0] sidx_r;
  logic [IW-1:0] ptr_r, ptr_nxt, pos_r, pos_nxt;
  logic [1:0] floor_r, floor_nxt;
  logic found_r, found_nxt;
  logic [4:0] evc_r, evc_nxt;
  logic ovalid_r;
  logic [143:0] odata_r, odata_nxt;
  logic pop_mode_r, pop_mode_nxt;

  logic [QUEUE_DEPTH-1:0] c_valid;
  logic [1:0] c_pri [QUEUE_DEPTH];
  logic [SIZE_BITS-1:0] c_size [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] c_tag [QUEUE_DEPTH];
  cell_ctl_t ctl;

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic nv;
      logic [1:0] np;
      logic [SIZE_BITS-1:0] ns;
      logic [TAG_BITS-1:0] nt;
      if (g == QUEUE_DEPTH - 1) begin : g_end
        assign nv = 1'b0;
        assign np = PRI_P0;
        assign ns = '0;
        assign nt = '0;
      end else begin : g_mid
        assign nv = c_valid[g+1];
        assign np = c_pri[g+1];
        assign ns = c_size[g+1];
        assign nt = c_tag[g+1];
      end
      ppq_cell #(.SIZE_BITS(SIZE_BITS), .TAG_BITS(TAG_BITS)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .shift_en(IW'(g) >= pos_r),
        .load_en(CW'(g) == count_r),
        .nb_valid(nv), .nb_pri(np), .nb_size(ns), .nb_tag(nt),
        .new_pri(ipri_r), .new_size(isize_r), .new_tag(itag_r),
        .valid(c_valid[g]), .pri(c_pri[g]), .size(c_size[g]), .tag(c_tag[g])
      );
    end
  endgenerate

  // effective limits
  logic [CW-1:0] eff_items;
  logic [31:0] eff_bytes;
  always_comb begin
    if (item_limit_r == 5'd0) eff_items = CW'(1);
    else if (32'(item_limit_r) > 32'(QUEUE_DEPTH)) eff_items = CW'(QUEUE_DEPTH);
    else eff_items = CW'(item_limit_r);
    eff_bytes = (byte_limit_r == 32'd0) ? 32'd1 : byte_limit_r;
  end
  logic need_room;
  assign need_room = (count_r >= eff_items) ||
    ({1'b0, 48'(bytes_r)} + {1'b0, 48'(isize_r)} > 49'(eff_bytes));

  logic [1:0] p_at;
  logic v_at;
  assign p_at = c_pri[ptr_r];
  assign v_at = CW'(ptr_r) < count_r;

  logic [CntW-1:0] drops_nxt [4];
  logic [CntW-1:0] pre_nxt, ovf_nxt, emg_nxt;
  logic [CntW-1:0] sval;

  function automatic logic [143:0] pack(input logic [2:0] st, input logic [TAG_BITS-1:0] t,
      input logic [1:0] p, input logic [SIZE_BITS-1:0] s, input logic [4:0] ev,
      input logic [4:0] hi, input logic [SIZE_BITS-1:0] hb, input logic [31:0] sv);
    return {1'b0, sv, 32'(hb), hi, ev, 32'(s), p, 32'(t), st};
  endfunction

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    bytes_nxt = bytes_r;
    ptr_nxt = ptr_r;
    pos_nxt = pos_r;
    floor_nxt = floor_r;
    found_nxt = found_r;
    evc_nxt = evc_r;
    pop_mode_nxt = pop_mode_r;
    odata_nxt = odata_r;
    ctl = '0;
    for (int k = 0; k < 4; k++) drops_nxt[k] = drops_r[k];
    pre_nxt = pre_r;
    ovf_nxt = ovf_r;
    emg_nxt = emg_r;
    if (sidx_r < 3'd4) sval = drops_r[sidx_r[1:0]];
    else if (sidx_r == 3'd4) sval = pre_r;
    else if (sidx_r == 3'd5) sval = ovf_r;
    else if (sidx_r == 3'd6) sval = emg_r;
    else sval = '0;
    unique case (state_r)
      S_IDLE: begin
        evc_nxt = '0;
        ptr_nxt = '0;
        pos_nxt = '0;
        found_nxt = 1'b0;
        if (in_tready && in_tvalid) begin
          unique case (cmd_t'(in_tdata[1:0]))
            CMD_PUSH: state_nxt = S_CHECK;
            CMD_POP: state_nxt = S_POPS;
            CMD_DRAIN: state_nxt = S_DRAIN;
            CMD_STAT: state_nxt = S_DONE;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_CHECK: begin
        ptr_nxt = '0;
        floor_nxt = PRI_P3;
        pop_mode_nxt = 1'b0;
        if (need_room) begin
          state_nxt = S_SCAN;
        end else begin
          ctl.load = 1'b1;
          count_nxt = count_r + 1'b1;
          bytes_nxt = bytes_r + isize_r;
          odata_nxt = pack(ST_ACCEPT, '0, PRI_P0, '0, evc_r, 5'(count_r + 1'b1),
                           bytes_r + isize_r, '0);
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        // walk the row looking for the oldest entry at this floor
        if (v_at && p_at == floor_r) begin
          pos_nxt = ptr_r;
          state_nxt = S_REM;
        end else if (!v_at || ptr_r == IW'(QUEUE_DEPTH - 1)) begin
          ptr_nxt = '0;
          if (floor_r == PRI_P3) floor_nxt = PRI_P2;
          else if (floor_r == PRI_P2 && ipri_r == PRI_P0) floor_nxt = PRI_P1;
          else begin
            drops_nxt[ipri_r] = sat_inc(drops_r[ipri_r]);
            ovf_nxt = sat_inc(ovf_r);
            if (ipri_r == PRI_P0) emg_nxt = sat_inc(emg_r);
            odata_nxt = pack((ipri_r == PRI_P0) ? ST_EMERG : ST_OVF, '0, PRI_P0, '0,
                             evc_r, 5'(count_r), bytes_r, '0);
            state_nxt = S_DONE;
          end
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_REM: begin
        ctl.shift = 1'b1;
        count_nxt = count_r - 1'b1;
        bytes_nxt = (bytes_r > c_size[pos_r]) ? bytes_r - c_size[pos_r] : '0;
        pos_nxt = '1;
        if (pop_mode_r) begin
          odata_nxt = pack(ST_POPPED, c_tag[pos_r], c_pri[pos_r], c_size[pos_r],
                           5'd0, 5'(count_r - 1'b1), bytes_nxt, '0);
          state_nxt = S_DONE;
        end else begin
          drops_nxt[c_pri[pos_r]] = sat_inc(drops_r[c_pri[pos_r]]);
          pre_nxt = sat_inc(pre_r);
          evc_nxt = evc_r + 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_POPS: begin
        pop_mode_nxt = 1'b1;
        if (count_r == '0) begin
          odata_nxt = pack(ST_EMPTY, '0, PRI_P0, '0, 5'd0, 5'd0, bytes_r, '0);
          state_nxt = S_DONE;
        end else begin
          if (!found_r || (v_at && p_at < c_pri[pos_r])) begin
            pos_nxt = ptr_r;
            found_nxt = 1'b1;
          end
          if (!v_at || ptr_r == IW'(QUEUE_DEPTH - 1)) state_nxt = S_REM;
          else ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (v_at) begin
          drops_nxt[p_at] = sat_inc(drops_r[p_at]);
          pre_nxt = sat_inc(pre_r);
        end
        if (!v_at || ptr_r == IW'(QUEUE_DEPTH - 1)) begin
          ctl.clear = 1'b1;
          count_nxt = '0;
          bytes_nxt = '0;
          odata_nxt = pack(ST_DRAINED, '0, PRI_P0, '0, 5'(count_r), 5'd0, '0, '0);
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_DONE: begin
        if (cmd_r == CMD_STAT)
          odata_nxt = pack(ST_STAT, '0, PRI_P0, '0, 5'd0, 5'(count_r), bytes_r, sval);
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_tready = (state_r == S_IDLE) && !ovalid_r;
  assign cfg_ready = 1'b1;
  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      item_limit_r <= 5'd16;
      byte_limit_r <= 32'd1048576;
      count_r <= '0;
      bytes_r <= '0;
      for (int k = 0; k < 4; k++) drops_r[k] <= '0;
      pre_r <= '0;
      ovf_r <= '0;
      emg_r <= '0;
      ovalid_r <= 1'b0;
      pos_r <= '1;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      bytes_r <= bytes_nxt;
      for (int k = 0; k < 4; k++) drops_r[k] <= drops_nxt[k];
      pre_r <= pre_nxt;
      ovf_r <= ovf_nxt;
      emg_r <= emg_nxt;
      pos_r <= pos_nxt;
      if (state_r == S_DONE) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      if (cfg_valid) begin
        if (cfg_index == CFG_ITEM_LIMIT) item_limit_r <= cfg_data[4:0];
        else byte_limit_r <= cfg_data;
      end
    end
    ptr_r <= ptr_nxt;
    floor_r <= floor_nxt;
    found_r <= found_nxt;
    evc_r <= evc_nxt;
    pop_mode_r <= pop_mode_nxt;
    odata_r <= odata_nxt;
    if (in_tready && in_tvalid) begin
      cmd_r <= in_tdata[1:0];
      ipri_r <= in_tdata[3:2];
      isize_r <= in_tdata[4 +: SIZE_BITS];
      itag_r <= in_tdata[4+SIZE_BITS +: TAG_BITS];
      sidx_r <= in_tdata[4+SIZE_BITS+TAG_BITS +: 3];
    end
  end
endmodule
